[sv/ray_triangle_intersect_macros.svh]
// ----------------------------------------------------------------------------
// ray_triangle_intersect_macros
// Assertion macros shared by the ray/triangle intersection tester.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/rti_pkg.sv]
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, register indexes and widths of the ray/triangle tester.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION_Y = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION_Z = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DIST    = 3'd6;

    localparam int MIN_DIST_W = 31;
    localparam int DIST_W     = 31;
    localparam int WEIGHT_W   = 17;
    localparam int QUOT_WIDTH = 32;
    localparam int NUM_LANES  = 4;

    localparam int LANE_DIST = 0;
    localparam int LANE_W1   = 1;
    localparam int LANE_W2   = 2;
    localparam int LANE_W3   = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic valid;
        logic keep;
    } side_t;

    function automatic int dot_width(int coord_width);
        return 3 * coord_width + 6;
    endfunction

endpackage

[sv/rti_stream_if.sv]
// ----------------------------------------------------------------------------
// rti_tri_if / rti_res_if
// Valid/ready channels for triangles in and intersection results out.
// ----------------------------------------------------------------------------
interface rti_tri_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex1_x;
    logic signed [COORD_WIDTH-1:0] vertex1_y;
    logic signed [COORD_WIDTH-1:0] vertex1_z;
    logic signed [COORD_WIDTH-1:0] vertex2_x;
    logic signed [COORD_WIDTH-1:0] vertex2_y;
    logic signed [COORD_WIDTH-1:0] vertex2_z;
    logic signed [COORD_WIDTH-1:0] vertex3_x;
    logic signed [COORD_WIDTH-1:0] vertex3_y;
    logic signed [COORD_WIDTH-1:0] vertex3_z;

    modport source (
        output valid, vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y,
               vertex2_z, vertex3_x, vertex3_y, vertex3_z,
        input  ready
    );
    modport sink (
        input  valid, vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y,
               vertex2_z, vertex3_x, vertex3_y, vertex3_z,
        output ready
    );
endinterface

interface rti_res_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [rti_pkg::DIST_W-1:0]    hit_distance;
    logic [rti_pkg::WEIGHT_W-1:0]  weight_p1;
    logic [rti_pkg::WEIGHT_W-1:0]  weight_p2;
    logic [rti_pkg::WEIGHT_W-1:0]  weight_p3;

    modport source (
        output valid, hit, hit_distance, weight_p1, weight_p2, weight_p3,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_distance, weight_p1, weight_p2, weight_p3,
        output ready
    );
endinterface

[sv/rti_geom.sv]
// ----------------------------------------------------------------------------
// rti_geom
// Six-stage geometry pipeline: edge vectors, cross products, dot products
// and sign normalization of the plane distance and edge weights.
// ----------------------------------------------------------------------------
module rti_geom #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic                                   in_valid,
    input  logic [2:0][2:0][COORD_WIDTH-1:0]       vertex,
    input  logic [2:0][COORD_WIDTH-1:0]            origin,
    input  logic [2:0][COORD_WIDTH-1:0]            direction,
    output rti_pkg::side_t                         side,
    output logic [rti_pkg::dot_width(COORD_WIDTH)-1:0] divisor,
    output logic [rti_pkg::NUM_LANES-1:0][rti_pkg::dot_width(COORD_WIDTH)+FRAC_BITS-1:0]
                                                   dividend
);

    localparam int C      = COORD_WIDTH;
    localparam int AW     = C + 1;
    localparam int PW     = 2 * C + 2;
    localparam int XW     = 2 * C + 3;
    localparam int LW     = C + 2;
    localparam int HW     = XW - LW;
    localparam int PLW    = AW + LW + 1;
    localparam int PHW    = AW + HW;
    localparam int DW     = rti_pkg::dot_width(C);
    localparam int DW1    = DW + 1;
    localparam int NW     = DW + FRAC_BITS;
    localparam int STAGES = 6;

    logic [STAGES-1:0] valid_reg;

    logic signed [AW-1:0]  a_reg [3][3];
    logic signed [AW-1:0]  e_reg [2][3];
    logic signed [AW-1:0]  d1_reg [3];

    logic signed [AW-1:0]  opu [4][3];
    logic signed [AW-1:0]  opv [4][3];
    logic signed [PW-1:0]  xp_reg [4][3][2];
    logic signed [AW-1:0]  a2_reg [3];
    logic signed [AW-1:0]  d2_reg [3];

    logic signed [XW-1:0]  x_reg [4][3];
    logic signed [AW-1:0]  a3_reg [3];
    logic signed [AW-1:0]  d3_reg [3];

    logic signed [AW-1:0]  lhs [5][3];
    logic signed [XW-1:0]  rhs [5][3];
    logic signed [PLW-1:0] plo_reg [5][3];
    logic signed [PHW-1:0] phi_reg [5][3];

    logic signed [DW-1:0]  dot_next [5];
    logic signed [DW-1:0]  dot_reg [5];

    logic signed [DW1-1:0] mag [5];
    logic                  keep_next;
    logic                  keep_reg;
    logic [DW-1:0]         den_reg;
    logic [rti_pkg::NUM_LANES-1:0][NW-1:0] divd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            opu[0][k] = e_reg[0][k];
            opv[0][k] = e_reg[1][k];
            opu[1][k] = a_reg[1][k];
            opv[1][k] = a_reg[2][k];
            opu[2][k] = a_reg[2][k];
            opv[2][k] = a_reg[0][k];
            opu[3][k] = a_reg[0][k];
            opv[3][k] = a_reg[1][k];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lhs[0][k] = d3_reg[k];
            rhs[0][k] = x_reg[0][k];
            lhs[1][k] = a3_reg[k];
            rhs[1][k] = x_reg[0][k];
            for (int j = 2; j < 5; j++)
            begin
                lhs[j][k] = d3_reg[k];
                rhs[j][k] = x_reg[j-1][k];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            dot_next[j] = '0;
            for (int k = 0; k < 3; k++)
            begin
                dot_next[j] = dot_next[j] + (DW'(phi_reg[j][k]) <<< LW)
                              + DW'(plo_reg[j][k]);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            mag[j] = dot_reg[0][DW-1] ? -DW1'(dot_reg[j]) : DW1'(dot_reg[j]);
        end
        keep_next = (dot_reg[0] != '0) && !mag[1][DW] && !mag[2][DW]
                    && !mag[3][DW] && !mag[4][DW];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    a_reg[i][k] <= AW'($signed(vertex[i][k])) - AW'($signed(origin[k]));
                end
                e_reg[0][k] <= AW'($signed(vertex[1][k])) - AW'($signed(vertex[0][k]));
                e_reg[1][k] <= AW'($signed(vertex[2][k])) - AW'($signed(vertex[1][k]));
                d1_reg[k]   <= AW'($signed(direction[k]));

                for (int c = 0; c < 4; c++)
                begin
                    xp_reg[c][k][0] <= opu[c][(k + 1) % 3] * opv[c][(k + 2) % 3];
                    xp_reg[c][k][1] <= opu[c][(k + 2) % 3] * opv[c][(k + 1) % 3];
                end
                a2_reg[k] <= a_reg[0][k];
                d2_reg[k] <= d1_reg[k];

                for (int c = 0; c < 4; c++)
                begin
                    x_reg[c][k] <= XW'(xp_reg[c][k][0]) - XW'(xp_reg[c][k][1]);
                end
                a3_reg[k] <= a2_reg[k];
                d3_reg[k] <= d2_reg[k];

                for (int j = 0; j < 5; j++)
                begin
                    plo_reg[j][k] <= lhs[j][k] * $signed({1'b0, rhs[j][k][LW-1:0]});
                    phi_reg[j][k] <= lhs[j][k] * $signed(rhs[j][k][XW-1:LW]);
                end
            end

            for (int j = 0; j < 5; j++)
            begin
                dot_reg[j] <= dot_next[j];
            end

            keep_reg <= keep_next;
            den_reg  <= mag[0][DW-1:0];
            for (int l = 0; l < rti_pkg::NUM_LANES; l++)
            begin
                divd_reg[l] <= mag[l+1][DW] ? '0 : {mag[l+1][DW-1:0], FRAC_BITS'(0)};
            end
        end
    end

    assign side.valid = valid_reg[STAGES-1];
    assign side.keep  = keep_reg;
    assign divisor    = den_reg;
    assign dividend   = divd_reg;

endmodule

[sv/rti_divide.sv]
// ----------------------------------------------------------------------------
// rti_divide
// Restoring divider pipeline, one quotient bit per stage, several dividends
// sharing one divisor. Flags quotients that do not fit the quotient width.
// ----------------------------------------------------------------------------
module rti_divide #(
    parameter int DEN_W = 102,
    parameter int NUM_W = 118
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               advance,
    input  rti_pkg::side_t                                     in_side,
    input  logic [DEN_W-1:0]                                   divisor,
    input  logic [rti_pkg::NUM_LANES-1:0][NUM_W-1:0]           dividend,
    output rti_pkg::side_t                                     out_side,
    output logic [rti_pkg::NUM_LANES-1:0][rti_pkg::QUOT_WIDTH-1:0] quotient,
    output logic [rti_pkg::NUM_LANES-1:0]                      saturated
);

    localparam int QW    = rti_pkg::QUOT_WIDTH;
    localparam int LN    = rti_pkg::NUM_LANES;
    localparam int CW    = DEN_W + QW + 1;
    localparam int DEPTH = QW + 1;

    logic [DEPTH-1:0]        valid_reg;
    logic [DEPTH-1:0]        keep_reg;
    logic [DEN_W-1:0]        den_reg [DEPTH];
    logic [NUM_W-1:0]        rem_reg [DEPTH][LN];
    logic [QW-1:0]           quo_reg [DEPTH][LN];
    logic [LN-1:0]           sat_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_side.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        logic [CW-1:0] step;
        logic          ge;
        if (advance)
        begin
            den_reg[0]  <= divisor;
            keep_reg[0] <= in_side.keep;
            for (int l = 0; l < LN; l++)
            begin
                rem_reg[0][l]    <= dividend[l];
                quo_reg[0][l]    <= '0;
                sat_reg[0][l]    <= CW'(dividend[l]) >= (CW'(divisor) << QW);
            end
            for (int s = 1; s < DEPTH; s++)
            begin
                den_reg[s]  <= den_reg[s-1];
                keep_reg[s] <= keep_reg[s-1];
                sat_reg[s]  <= sat_reg[s-1];
                step = CW'(den_reg[s-1]) << (QW - s);
                for (int l = 0; l < LN; l++)
                begin
                    ge = CW'(rem_reg[s-1][l]) >= step;
                    rem_reg[s][l] <= ge ? rem_reg[s-1][l] - NUM_W'(step) : rem_reg[s-1][l];
                    quo_reg[s][l] <= quo_reg[s-1][l] | (ge ? (QW'(1) << (QW - s)) : '0);
                end
            end
        end
    end

    assign out_side.valid = valid_reg[DEPTH-1];
    assign out_side.keep  = keep_reg[DEPTH-1];

    always_comb
    begin
        for (int l = 0; l < LN; l++)
        begin
            quotient[l] = quo_reg[DEPTH-1][l];
        end
        saturated = sat_reg[DEPTH-1];
    end

endmodule

[sv/ray_triangle_intersect.sv]
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Pipelined ray/triangle intersection tester with barycentric weights.
// ----------------------------------------------------------------------------
// The ray (origin, direction, minimum distance) sits in seven registers that
// are written through cfg_we/cfg_index/cfg_data. The user must write them only
// while no triangle is in flight; the block itself does not enforce this.
// Triangles arrive on the triangle channel, one per transfer, as nine signed
// fixed-point coordinates. Each triangle gives exactly one transfer on the
// result channel, in order: hit, hit distance and the three vertex weights,
// all zero on a miss (including parallel rays and degenerate triangles).
// A triangle can be taken in every cycle while the result receiver does not
// stall. The result passes through six geometry stages (differences, cross
// products, their differences, split dot-product partials, their sums, sign
// normalization), 33 divider stages (overflow check and one quotient bit per
// stage for all four quotients) and the output register.
// When the result receiver stalls, the whole pipeline holds and triangle
// ready drops; bubbles do not collapse. Reset clears all valid bits and loads
// the default ray: origin zero, direction +z, minimum distance 66.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rti_tri_if.sink                             triangle,
    rti_res_if.source                           result,
    input  logic                                cfg_we,
    input  logic [rti_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [((COORD_WIDTH > 31) ? COORD_WIDTH : 31)-1:0] cfg_data
);

`include "ray_triangle_intersect_macros.svh"

    localparam int C  = COORD_WIDTH;
    localparam int DW = rti_pkg::dot_width(C);
    localparam int NW = DW + FRAC_BITS;
    localparam int QW = rti_pkg::QUOT_WIDTH;
    localparam logic [QW-1:0] WEIGHT_CAP = QW'(64'd1 << FRAC_BITS);

    logic [2:0][C-1:0] origin_reg;
    logic [2:0][C-1:0] direction_reg;
    logic [rti_pkg::MIN_DIST_W-1:0] min_distance_reg;

    logic advance;
    logic [2:0][2:0][C-1:0] vertex;

    rti_pkg::side_t geom_side;
    rti_pkg::side_t div_side;
    logic [DW-1:0] divisor;
    logic [rti_pkg::NUM_LANES-1:0][NW-1:0] dividend;
    logic [rti_pkg::NUM_LANES-1:0][QW-1:0] quotient;
    logic [rti_pkg::NUM_LANES-1:0] saturated;

    logic                            hit_next;
    logic [rti_pkg::DIST_W-1:0]      dist_next;
    logic [QW-1:0]                   wq [3];
    logic [rti_pkg::WEIGHT_W-1:0]    w_next [3];

    logic                            res_valid_reg;
    logic                            res_hit_reg;
    logic [rti_pkg::DIST_W-1:0]      res_dist_reg;
    logic [rti_pkg::WEIGHT_W-1:0]    res_w_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg       <= '0;
            direction_reg[0] <= '0;
            direction_reg[1] <= '0;
            direction_reg[2] <= C'(64'd65536);
            min_distance_reg <= rti_pkg::MIN_DIST_W'(66);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rti_pkg::REG_ORIGIN_X:    origin_reg[0]    <= cfg_data[C-1:0];
                rti_pkg::REG_ORIGIN_Y:    origin_reg[1]    <= cfg_data[C-1:0];
                rti_pkg::REG_ORIGIN_Z:    origin_reg[2]    <= cfg_data[C-1:0];
                rti_pkg::REG_DIRECTION_X: direction_reg[0] <= cfg_data[C-1:0];
                rti_pkg::REG_DIRECTION_Y: direction_reg[1] <= cfg_data[C-1:0];
                rti_pkg::REG_DIRECTION_Z: direction_reg[2] <= cfg_data[C-1:0];
                rti_pkg::REG_MIN_DIST:
                    min_distance_reg <= cfg_data[rti_pkg::MIN_DIST_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance        = !res_valid_reg || result.ready;
    assign triangle.ready = advance;

    assign vertex[0] = {triangle.vertex1_z, triangle.vertex1_y, triangle.vertex1_x};
    assign vertex[1] = {triangle.vertex2_z, triangle.vertex2_y, triangle.vertex2_x};
    assign vertex[2] = {triangle.vertex3_z, triangle.vertex3_y, triangle.vertex3_x};

    rti_geom #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (triangle.valid),
        .vertex    (vertex),
        .origin    (origin_reg),
        .direction (direction_reg),
        .side      (geom_side),
        .divisor   (divisor),
        .dividend  (dividend)
    );

    rti_divide #(
        .DEN_W (DW),
        .NUM_W (NW)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_side   (geom_side),
        .divisor   (divisor),
        .dividend  (dividend),
        .out_side  (div_side),
        .quotient  (quotient),
        .saturated (saturated)
    );

    always_comb
    begin
        hit_next = div_side.keep
                   && (saturated[rti_pkg::LANE_DIST]
                       || (quotient[rti_pkg::LANE_DIST] >= QW'(min_distance_reg)));
        if (!hit_next)
        begin
            dist_next = '0;
        end
        else if (saturated[rti_pkg::LANE_DIST]
                 || (quotient[rti_pkg::LANE_DIST] > QW'(rti_pkg::DIST_MAX)))
        begin
            dist_next = rti_pkg::DIST_MAX;
        end
        else
        begin
            dist_next = quotient[rti_pkg::LANE_DIST][rti_pkg::DIST_W-1:0];
        end
        for (int k = 0; k < 3; k++)
        begin
            wq[k] = (saturated[rti_pkg::LANE_W1 + k]
                     || (quotient[rti_pkg::LANE_W1 + k] > WEIGHT_CAP))
                    ? WEIGHT_CAP : quotient[rti_pkg::LANE_W1 + k];
            w_next[k] = hit_next ? wq[k][rti_pkg::WEIGHT_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= div_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_hit_reg  <= hit_next;
            res_dist_reg <= dist_next;
            for (int k = 0; k < 3; k++)
            begin
                res_w_reg[k] <= w_next[k];
            end
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.hit          = res_hit_reg;
    assign result.hit_distance = res_dist_reg;
    assign result.weight_p1    = res_w_reg[0];
    assign result.weight_p2    = res_w_reg[1];
    assign result.weight_p3    = res_w_reg[2];

    `RTI_ASSERT_IMP(a_miss_is_zero, clk, rst_n, result.valid && !result.hit, (result.hit_distance == '0) && (result.weight_p1 == '0) && (result.weight_p2 == '0) && (result.weight_p3 == '0))
    `RTI_ASSERT_IMP(a_stall_only_when_blocked, clk, rst_n, !triangle.ready, result.valid && !result.ready)
    `RTI_ASSERT_IMP(a_weight_capped, clk, rst_n, result.valid && result.hit, (QW'(result.weight_p1) <= WEIGHT_CAP) && (QW'(result.weight_p2) <= WEIGHT_CAP))
    `RTI_ASSERT_NEXT(a_drain, clk, rst_n, result.valid && result.ready && !div_side.valid, !result.valid)

endmodule

[sim/ray_triangle_intersect_test.sv]
// ----------------------------------------------------------------------------
// ray_triangle_intersect_test
// Self-checking testbench for the ray/triangle intersection tester.
// ----------------------------------------------------------------------------
// Triangles are streamed against a series of ray settings. Each triangle
// transfer is predicted with exact wide integer arithmetic, and every result
// transfer is compared field by field with the oldest prediction. The sender
// and the receiver idle at random in several phases.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rti_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;
    localparam longint ONE = 65536;

    typedef logic signed [255:0] wide_t;
    typedef struct {
        wide_t x;
        wide_t y;
        wide_t z;
    } vec_t;
    typedef struct packed {
        logic [8:0][CW-1:0] c;
    } tri_t;
    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [WEIGHT_W-1:0] w1;
        logic [WEIGHT_W-1:0] w2;
        logic [WEIGHT_W-1:0] w3;
    } hit_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    rti_tri_if #(.COORD_WIDTH(CW)) triangle_ch ();
    rti_res_if result_ch ();

    ray_triangle_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .triangle (triangle_ch.sink),
        .result   (result_ch.source),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    logic [CW-1:0] ray_reg [6];
    logic [MIN_DIST_W-1:0] ray_min;

    tri_t pending_tris[$];
    hit_t expected_hits[$];
    int send_idle_pct;
    int stall_pct;
    bit took;
    int failures;
    int idle_cycles;
    int hits_seen;
    int misses_seen;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic vec_t vsub(vec_t a, vec_t b);
        vec_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic vec_t vcross(vec_t a, vec_t b);
        vec_t r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    function automatic wide_t vdot(vec_t a, vec_t b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    function automatic vec_t to_vec(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        vec_t r;
        r.x = $signed(x);
        r.y = $signed(y);
        r.z = $signed(z);
        return r;
    endfunction

    function automatic wide_t scaled_quotient(wide_t n, wide_t d, wide_t cap);
        wide_t q;
        q = (n <<< FB) / d;
        return (q > cap) ? cap : q;
    endfunction

    function automatic hit_t predict_hit(tri_t t);
        hit_t r;
        vec_t o;
        vec_t d;
        vec_t a1;
        vec_t a2;
        vec_t a3;
        vec_t n;
        wide_t den;
        wide_t num;
        wide_t w1;
        wide_t w2;
        wide_t w3;
        wide_t md;
        wide_t q;
        r = '0;
        o = to_vec(ray_reg[0], ray_reg[1], ray_reg[2]);
        d = to_vec(ray_reg[3], ray_reg[4], ray_reg[5]);
        a1 = vsub(to_vec(t.c[0], t.c[1], t.c[2]), o);
        a2 = vsub(to_vec(t.c[3], t.c[4], t.c[5]), o);
        a3 = vsub(to_vec(t.c[6], t.c[7], t.c[8]), o);
        n = vcross(vsub(a2, a1), vsub(a3, a2));
        den = vdot(d, n);
        if (den == 0)
            return r;
        num = vdot(a1, n);
        w3 = vdot(d, vcross(a1, a2));
        w1 = vdot(d, vcross(a2, a3));
        w2 = vdot(d, vcross(a3, a1));
        if (den < 0)
        begin
            den = -den;
            num = -num;
            w1 = -w1;
            w2 = -w2;
            w3 = -w3;
        end
        md = {225'b0, ray_min};
        if ((num <<< FB) < md * den)
            return r;
        if (w1 < 0 || w2 < 0 || w3 < 0)
            return r;
        r.hit = 1'b1;
        q = scaled_quotient(num, den, {225'b0, DIST_MAX});
        r.distance = q[DIST_W-1:0];
        q = scaled_quotient(w1, den, ONE);
        r.w1 = q[WEIGHT_W-1:0];
        q = scaled_quotient(w2, den, ONE);
        r.w2 = q[WEIGHT_W-1:0];
        q = scaled_quotient(w3, den, ONE);
        r.w3 = q[WEIGHT_W-1:0];
        return r;
    endfunction

    // Triangle driver; also drives the random result ready.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            triangle_ch.valid <= 1'b0;
            triangle_ch.vertex1_x <= '0;
            triangle_ch.vertex1_y <= '0;
            triangle_ch.vertex1_z <= '0;
            triangle_ch.vertex2_x <= '0;
            triangle_ch.vertex2_y <= '0;
            triangle_ch.vertex2_z <= '0;
            triangle_ch.vertex3_x <= '0;
            triangle_ch.vertex3_y <= '0;
            triangle_ch.vertex3_z <= '0;
        end
        else if (!triangle_ch.valid || took)
        begin
            took = 1'b0;
            if (pending_tris.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                triangle_ch.valid <= 1'b1;
                triangle_ch.vertex1_x <= pending_tris[0].c[0];
                triangle_ch.vertex1_y <= pending_tris[0].c[1];
                triangle_ch.vertex1_z <= pending_tris[0].c[2];
                triangle_ch.vertex2_x <= pending_tris[0].c[3];
                triangle_ch.vertex2_y <= pending_tris[0].c[4];
                triangle_ch.vertex2_z <= pending_tris[0].c[5];
                triangle_ch.vertex3_x <= pending_tris[0].c[6];
                triangle_ch.vertex3_y <= pending_tris[0].c[7];
                triangle_ch.vertex3_z <= pending_tris[0].c[8];
            end
            else
                triangle_ch.valid <= 1'b0;
        end
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: predicts on triangle transfers, checks result transfers.
    always @(posedge clk)
    begin
        tri_t t;
        hit_t got;
        if (rst_n)
        begin
            if ((triangle_ch.valid && triangle_ch.ready)
                || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (triangle_ch.valid && triangle_ch.ready)
            begin
                t.c[0] = triangle_ch.vertex1_x;
                t.c[1] = triangle_ch.vertex1_y;
                t.c[2] = triangle_ch.vertex1_z;
                t.c[3] = triangle_ch.vertex2_x;
                t.c[4] = triangle_ch.vertex2_y;
                t.c[5] = triangle_ch.vertex2_z;
                t.c[6] = triangle_ch.vertex3_x;
                t.c[7] = triangle_ch.vertex3_y;
                t.c[8] = triangle_ch.vertex3_z;
                expected_hits.push_back(predict_hit(t));
                void'(pending_tris.pop_front());
                took = 1'b1;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got.hit = result_ch.hit;
                got.distance = result_ch.hit_distance;
                got.w1 = result_ch.weight_p1;
                got.w2 = result_ch.weight_p2;
                got.w3 = result_ch.weight_p3;
                if (expected_hits.size() == 0)
                begin
                    $error("result transfer with no triangle outstanding");
                    failures++;
                end
                else
                begin
                    if (got.hit) hits_seen++; else misses_seen++;
                    if (got.hit !== expected_hits[0].hit)
                    begin
                        $error("hit: expected %0d, got %0d", expected_hits[0].hit, got.hit);
                        failures++;
                    end
                    if (got.distance !== expected_hits[0].distance)
                    begin
                        $error("hit_distance: expected %0d, got %0d",
                               expected_hits[0].distance, got.distance);
                        failures++;
                    end
                    if (got.w1 !== expected_hits[0].w1)
                    begin
                        $error("weight_p1: expected %0d, got %0d", expected_hits[0].w1, got.w1);
                        failures++;
                    end
                    if (got.w2 !== expected_hits[0].w2)
                    begin
                        $error("weight_p2: expected %0d, got %0d", expected_hits[0].w2, got.w2);
                        failures++;
                    end
                    if (got.w3 !== expected_hits[0].w3)
                    begin
                        $error("weight_p3: expected %0d, got %0d", expected_hits[0].w3, got.w3);
                        failures++;
                    end
                    void'(expected_hits.pop_front());
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL ray_triangle_intersect");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx <= REG_DIRECTION_Z)
            ray_reg[idx] = value;
        else if (idx == REG_MIN_DIST)
            ray_min = value[MIN_DIST_W-1:0];
    endtask

    task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           logic [31:0] md);
        while (pending_tris.size() > 0 || expected_hits.size() > 0 || triangle_ch.valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIRECTION_X, dx);
        write_reg(REG_DIRECTION_Y, dy);
        write_reg(REG_DIRECTION_Z, dz);
        write_reg(REG_MIN_DIST, md);
        write_reg(REG_UNUSED, $urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic tri_t tri_of(longint p [9]);
        tri_t t;
        for (int i = 0; i < 9; i++)
            t.c[i] = p[i][CW-1:0];
        return t;
    endfunction

    function automatic tri_t random_tri();
        longint p [9];
        longint ctr [3];
        longint span;
        int kind;
        int k;
        kind = $urandom_range(99);
        k = $urandom_range(32);
        span = longint'(1) << $urandom_range(22, 4);
        for (int a = 0; a < 3; a++)
            ctr[a] = longint'($signed(ray_reg[a])) + ((longint'($signed(ray_reg[a + 3])) * k) >>> 2);
        for (int i = 0; i < 9; i++)
        begin
            if (kind < 70)
                p[i] = ctr[i % 3] + $signed($urandom_range(2 * span)) - span;
            else if (kind < 85)
                p[i] = $signed($urandom);
            else
                p[i] = $signed($urandom_range(2 * span)) - span;
        end
        if (kind >= 92)
        begin
            // Degenerate: two vertices coincide or all three lie on a line.
            for (int a = 0; a < 3; a++)
                p[6 + a] = (kind[0]) ? p[a] : 2 * p[3 + a] - p[a];
        end
        return tri_of(p);
    endfunction

    task automatic push_tri(longint a, longint b, longint c, longint d, longint e,
                            longint f, longint g, longint h, longint i);
        longint p [9];
        p = '{a, b, c, d, e, f, g, h, i};
        pending_tris.push_back(tri_of(p));
    endtask

    initial
    begin
        longint mx;
        longint mn;
        mx = 64'sh7FFFFFFF;
        mn = -64'sh80000000;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        took = 1'b0;
        failures = 0;
        idle_cycles = 0;
        hits_seen = 0;
        misses_seen = 0;
        triangle_ch.valid = 1'b0;
        result_ch.ready = 1'b0;
        for (int i = 0; i < 6; i++)
            ray_reg[i] = '0;
        ray_reg[REG_DIRECTION_Z] = CW'(ONE);
        ray_min = MIN_DIST_W'(66);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed triangles against the reset ray along +z.
        push_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE);
        push_tri(0, ONE, ONE, ONE, -ONE, ONE, -ONE, -ONE, ONE);
        push_tri(0, 0, 2 * ONE, ONE, 0, 2 * ONE, 0, ONE, 2 * ONE);
        push_tri(-ONE, 0, ONE, ONE, 0, ONE, 0, ONE, ONE);
        push_tri(3 * ONE, -ONE, ONE, 5 * ONE, -ONE, ONE, 4 * ONE, ONE, ONE);
        push_tri(-ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, ONE, -ONE);
        push_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0);
        push_tri(-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1);
        push_tri(0, 0, ONE, 0, ONE, 2 * ONE, 0, -ONE, 3 * ONE);
        push_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
        push_tri(0, 0, ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE, ONE);
        push_tri(-1, -1, mx, 1, -1, mx, 0, 1, mx);
        push_tri(mn, mn, mx, mx, mn, mx, 0, mx, mx);
        push_tri(mn, mn, mn, mx, mn, mn, 0, mx, mn);
        push_tri(mx, mx, mx, mn, mn, mn, mx, mn, mx);
        push_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx);
        push_tri(mx, mx, mx, mx, mx, mx, mn, mn, mn);
        push_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_tri(-1, -1, 1, 1, -1, 1, 0, 1, 1);

        // Tiny direction so that distant triangles saturate the distance.
        set_ray(0, 0, 0, 0, 0, 1, 0);
        push_tri(-ONE, -ONE, mx, ONE, -ONE, mx, 0, ONE, mx);
        push_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE);
        push_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0);
        set_ray(mx, mx, mx, mn, mn, mn, 32'hFFFF_FFFF);
        push_tri(0, 0, 0, mn, mn, mx, mx, mn, mn);
        push_tri(mn, mn, mn, mx, mx, mn, mn, mx, mx);
        push_tri(0, 0, 0, 0, 0, 0, 1, 2, 3);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 80; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 80; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            case (phase)
                0: set_ray(0, 0, 0, 0, 0, ONE, 0);
                3: set_ray(mn, mn, mn, mx, mx, mx, 32'h7FFF_FFFF);
                6: set_ray(mx, mn, mx, mn, mx, mn, 32'h8000_0000);
                default: set_ray($urandom_range(ONE * 16) - ONE * 8, $urandom_range(ONE * 16) - ONE * 8,
                                 $urandom, $urandom_range(ONE * 4) - ONE * 2,
                                 $urandom_range(ONE * 4) - ONE * 2,
                                 $urandom >> $urandom_range(31), $urandom_range(ONE * 4));
            endcase
            for (int n = 0; n < 160; n++)
                pending_tris.push_back(random_tri());
        end

        while (pending_tris.size() > 0 || expected_hits.size() > 0 || triangle_ch.valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d hits and %0d misses over eleven ray settings,", hits_seen,
                 misses_seen);
        $display("including saturated distances, parallel rays and degenerate triangles.");
        if (failures == 0)
            $display("PASS ray_triangle_intersect");
        else
            $display("FAIL ray_triangle_intersect");
        $finish;
    end
endmodule

[filelist.f]
+incdir+sv
sv/rti_pkg.sv
sv/rti_stream_if.sv
sv/rti_geom.sv
sv/rti_divide.sv
sv/ray_triangle_intersect.sv
sim/ray_triangle_intersect_test.sv
